@@ sv/pfe_pkg.sv @@
package pfe_pkg;

    // ASCII codes recognised by the evaluator
    localparam logic [7:0] SYM_ZERO  = 8'h30;
    localparam logic [7:0] SYM_NINE  = 8'h39;
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] SYM_STAR  = 8'h2A;
    localparam logic [7:0] SYM_SLASH = 8'h2F;

    // value read for a missing operand or an empty stack
    localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    localparam int WORD_W = 32;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } sym_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               underflow_seen;
        logic               overflow_seen;
        logic               divide_by_zero_seen;
        logic [6:0]         depth_left;
    } res_t;

    typedef struct packed {
        logic under;
        logic over;
        logic div0;
    } flags_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DIV,
        S_WRITE,
        S_FINISH
    } state_t;

endpackage

@@ sv/pfe_divider.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
module pfe_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [31:0]      rem_reg,   rem_next;
    logic [31:0]      quo_reg,   quo_next;
    logic [31:0]      dsr_reg,   dsr_next;
    logic [32:0]      rem_shift;
    logic [32:0]      diff;

    assign rem_shift = {rem_reg, quo_reg[31]};
    assign diff      = rem_shift - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/postfix_expression_evaluator.sv @@
// Channel   Direction  Handshake              Payload
// sym       in         sym_valid / sym_stall  pfe_pkg::sym_t (symbol, last_symbol)
// res       out        res_valid / res_stall  pfe_pkg::res_t (value, flags, depth)
//
// Steps: a digit or an ignored character is taken in the idle state; + - *
// go through accept, operand fetch and write-back; / also waits on the
// 32-step divider between fetch and write-back, unless the divisor is zero.
// A last symbol adds a finish state to hand the result to the output register.
// Reset: asynchronous, active low; clears count, flags and control. The stack
// memory is not cleared, entries at or above the count are never used.
// Stalls: res_stall only holds the output register; a new symbol is taken while
// a result waits, and only the next result waits for the register to free.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sym_valid,
    output logic          sym_stall,
    input  pfe_pkg::sym_t sym_data,
    output logic          res_valid,
    input  logic          res_stall,
    output pfe_pkg::res_t res_data
);
    import pfe_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    // Operand stack: one write port, one registered read port.
    // top_reg mirrors the entry at count-1, so only the left operand is read.
    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] rd_data_reg;

    state_t       state_reg,  state_next;
    logic [CW-1:0] count_reg, count_next;
    flags_t       flags_reg,  flags_next;
    logic [31:0]  top_reg,    top_next;
    op_t          op_reg,     op_next;
    logic         last_reg,   last_next;
    logic [31:0]  result_reg, result_next;
    logic         neg_reg,    neg_next;
    logic         res_valid_reg, res_valid_next;
    res_t         res_data_reg,  res_data_next;

    logic          accept;
    op_t           sym_op;
    logic          sym_digit;
    logic [7:0]    digit_val;
    logic [CW-1:0] rd_index;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [31:0]   left_op;
    logic [31:0]   right_op;
    logic [CW-1:0] popped_count;
    logic          out_free;
    logic [CW+6:0] depth_ext;

    logic          div_start;
    logic [31:0]   div_dividend;
    logic [31:0]   div_divisor;
    logic          div_done;
    logic [31:0]   div_quotient;

    assign sym_stall = (state_reg != S_IDLE);
    assign accept    = sym_valid && !sym_stall;
    assign out_free  = !res_valid_reg || !res_stall;

    // symbol decode
    always_comb
    begin
        unique case (sym_data.symbol)
            SYM_PLUS:  sym_op = OP_ADD;
            SYM_MINUS: sym_op = OP_SUB;
            SYM_STAR:  sym_op = OP_MUL;
            SYM_SLASH: sym_op = OP_DIV;
            default:   sym_op = OP_NONE;
        endcase
    end

    assign sym_digit = (sym_data.symbol >= SYM_ZERO) && (sym_data.symbol <= SYM_NINE);
    assign digit_val = sym_data.symbol - SYM_ZERO;

    // left operand sits two below the count; read every cycle, count is
    // steady between accepting an operator and the fetch cycle
    assign rd_index = count_reg - CW'(2);
    assign rd_addr  = rd_index[AW-1:0];

    assign right_op     = (count_reg != '0) ? top_reg : EMPTY_VALUE;
    assign left_op      = (count_reg >= CW'(2)) ? rd_data_reg : EMPTY_VALUE;
    assign popped_count = (count_reg >= CW'(2)) ? (count_reg - CW'(2)) : '0;

    assign div_dividend = left_op[31] ? (32'd0 - left_op) : left_op;
    assign div_divisor  = right_op[31] ? (32'd0 - right_op) : right_op;

    assign depth_ext = {7'd0, count_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sym_op != OP_NONE)
                        state_next = S_FETCH;
                    else if (sym_data.last_symbol)
                        state_next = S_FINISH;
                end
            end
            S_FETCH:
            begin
                if (op_reg == OP_DIV && right_op != '0)
                    state_next = S_DIV;
                else
                    state_next = S_WRITE;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                state_next = last_reg ? S_FINISH : S_IDLE;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        flags_next     = flags_reg;
        top_next       = top_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        result_next    = result_reg;
        neg_next       = neg_reg;
        res_data_next  = res_data_reg;
        res_valid_next = res_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = result_reg;
        div_start      = 1'b0;

        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = sym_op;
                    last_next = sym_data.last_symbol;
                    if (sym_op == OP_NONE && sym_digit)
                    begin
                        if (count_reg == FULL_COUNT)
                            flags_next.over = 1'b1;
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_data    = {24'd0, digit_val};
                            top_next   = {24'd0, digit_val};
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
            end
            S_FETCH:
            begin
                if (count_reg < CW'(2))
                    flags_next.under = 1'b1;
                count_next = popped_count;
                unique case (op_reg)
                    OP_ADD: result_next = left_op + right_op;
                    OP_SUB: result_next = left_op - right_op;
                    OP_MUL: result_next = left_op * right_op;
                    OP_DIV:
                    begin
                        if (right_op == '0)
                        begin
                            flags_next.div0 = 1'b1;
                            result_next     = '0;
                        end
                        else
                        begin
                            div_start = 1'b1;
                            neg_next  = left_op[31] ^ right_op[31];
                        end
                    end
                    default: result_next = result_reg;
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                    result_next = neg_reg ? (32'd0 - div_quotient) : div_quotient;
            end
            S_WRITE:
            begin
                // pops leave room, so the push always lands
                wr_en      = 1'b1;
                wr_data    = result_reg;
                top_next   = result_reg;
                count_next = count_reg + CW'(1);
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next                    = 1'b1;
                    res_data_next.result_value        = (count_reg != '0) ? top_reg
                                                                          : EMPTY_VALUE;
                    res_data_next.underflow_seen      = flags_reg.under || (count_reg == '0);
                    res_data_next.overflow_seen       = flags_reg.over;
                    res_data_next.divide_by_zero_seen = flags_reg.div0;
                    res_data_next.depth_left          = depth_ext[6:0];
                    count_next                        = '0;
                    flags_next                        = '0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    pfe_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            flags_reg     <= '0;
            op_reg        <= OP_NONE;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            flags_reg     <= flags_next;
            op_reg        <= op_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        result_reg   <= result_next;
        neg_reg      <= neg_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule
